>>> hdl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window maximum
// Default sizes, config register width and the per-cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  // Default sizes for the top-level parameters
  localparam int unsigned MAX_WINDOW_DEF   = 64;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;

  // Width of the window_size config register
  localparam int unsigned WS_W = 7;

  // Control broadcast from the top level to every candidate cell
  typedef struct packed {
    logic step;   // a sample transaction is accepted this cycle
    logic purge;  // drop the head candidate, shift the row toward the head
    logic shift;  // head candidate expires during this step
    logic clear;  // end of sequence: empty the row after this step
  } cell_ctrl_t;

endpackage : swm_pkg

`default_nettype wire

>>> hdl/sliding_window_maximum.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum: streaming maximum over the last window_size samples
// A row of candidate cells forms a monotonic queue; the head is the maximum.
// ----------------------------------------------------------------------------
// Usage: samples enter on the input channel at up to one transaction per
// cycle. The row of MAX_WINDOW cells keeps the candidates for the window
// maximum ordered oldest (cell 0) to newest, values strictly decreasing, so
// the head cell is always the answer. Every cell compares its candidate with
// the incoming sample in parallel and the row shifts by at most one place per
// cycle, which is what sets the one-sample-per-cycle rate. Once window_size
// samples of a sequence have been seen, each sample yields one result in the
// cycle after it is accepted; the result register frees up in the same cycle
// it is taken, so a stalled output only holds up input while it is full.
// A sample with end_of_sequence set tags its result as last_window and empties
// the row; a sequence shorter than the window yields nothing. The user is
// to write window_size only while the block is idle; the block does not
// enforce it (0 acts as 1, above MAX_WINDOW saturates). After a shrink,
// candidates older than the new window drop from the head one per cycle,
// stalling input until done; none after a grow or an unchanged write.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_maximum #(
  parameter int unsigned MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // configuration write channel
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [swm_pkg::WS_W-1:0]       cfg_window_size_i,
  // sample input channel
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire signed [SAMPLE_WIDTH-1:0]  sample_i,
  input  wire                            end_of_sequence_i,
  // result output channel
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] window_max_o,
  output logic                           last_window_o
);

  localparam int unsigned AGE_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SEEN_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CMP_W  = (SEEN_W > swm_pkg::WS_W) ? SEEN_W : swm_pkg::WS_W;

  // Config register
  logic [swm_pkg::WS_W-1:0] window_size_q;
  logic [CMP_W-1:0]         ws_ext;
  logic [CMP_W-1:0]         k_wide;
  logic [SEEN_W-1:0]        k_eff;

  // Row of cells; index MAX_WINDOW is the empty tie-off past the tail
  logic signed [SAMPLE_WIDTH-1:0] cell_value [MAX_WINDOW+1];
  logic [AGE_W-1:0]               cell_age   [MAX_WINDOW+1];
  logic                           cell_valid [MAX_WINDOW+1];
  logic                           cell_keep  [MAX_WINDOW+1];

  swm_pkg::cell_ctrl_t ctrl;

  logic [SEEN_W-1:0] seen_q, seen_d;
  logic [SEEN_W-1:0] seen_nxt;
  logic [SEEN_W-1:0] head_age;

  logic in_accept;
  logic head_expire;   // head candidate leaves the window on this sample
  logic purge_needed;  // head already outside a shrunk window
  logic produce;
  logic head_src_keep;
  logic signed [SAMPLE_WIDTH-1:0] best;

  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] window_max_q;
  logic                           last_window_q;

  // --------------------------------------------------------------------------
  // Configuration: always ready; user-kept: written only while idle
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= swm_pkg::WS_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      window_size_q <= cfg_window_size_i;
    end
  end

  // Effective window length: zero acts as one, saturate at the row length
  always_comb begin
    ws_ext = CMP_W'(window_size_q);
    if (ws_ext == '0) begin
      k_wide = CMP_W'(1);
    end else if (ws_ext > CMP_W'(MAX_WINDOW)) begin
      k_wide = CMP_W'(MAX_WINDOW);
    end else begin
      k_wide = ws_ext;
    end
  end
  assign k_eff = k_wide[SEEN_W-1:0];

  // --------------------------------------------------------------------------
  // Handshake and row control
  // --------------------------------------------------------------------------
  // Ages strictly decrease from the head, so only the head can run out of the
  // window on a step; several stale heads only appear after a shrink.
  assign head_age     = SEEN_W'(cell_age[0]);
  assign purge_needed = cell_valid[0] && (head_age >= k_eff);
  assign head_expire  = cell_valid[0] && ((head_age + SEEN_W'(1)) >= k_eff);

  assign in_stall_o = purge_needed || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    ctrl.step  = in_accept;
    ctrl.purge = purge_needed;
    ctrl.shift = head_expire;
    ctrl.clear = end_of_sequence_i;
  end

  // --------------------------------------------------------------------------
  // Candidate row
  // --------------------------------------------------------------------------
  assign cell_value[MAX_WINDOW] = '0;
  assign cell_age[MAX_WINDOW]   = '0;
  assign cell_valid[MAX_WINDOW] = 1'b0;
  assign cell_keep[MAX_WINDOW]  = 1'b0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic lkeep;
    if (i == 0) begin : g_head
      assign lkeep = 1'b1;
    end else begin : g_body
      assign lkeep = cell_keep[i-1];
    end

    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .AGE_W        (AGE_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .head_i    ((i == 0) ? 1'b1 : 1'b0),
      .sample_i  (sample_i),
      .lkeep_i   (lkeep),
      .r_value_i (cell_value[i+1]),
      .r_age_i   (cell_age[i+1]),
      .r_valid_i (cell_valid[i+1]),
      .r_keep_i  (cell_keep[i+1]),
      .value_o   (cell_value[i]),
      .age_o     (cell_age[i]),
      .valid_o   (cell_valid[i]),
      .keep_o    (cell_keep[i])
    );
  end

  // The window maximum is whatever lands in the head cell on this step:
  // the oldest survivor, or the new sample when nothing survives.
  always_comb begin
    head_src_keep = head_expire ? cell_keep[1] : cell_keep[0];
    if (head_src_keep) begin
      best = head_expire ? cell_value[1] : cell_value[0];
    end else begin
      best = sample_i;
    end
  end

  // --------------------------------------------------------------------------
  // Sample count of the current sequence, saturating at the row length
  // --------------------------------------------------------------------------
  assign seen_nxt = (seen_q == SEEN_W'(MAX_WINDOW)) ? seen_q : (seen_q + SEEN_W'(1));
  assign produce  = seen_nxt >= k_eff;

  always_comb begin
    seen_d = seen_q;
    if (in_accept) begin
      seen_d = end_of_sequence_i ? '0 : seen_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= in_accept && produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && produce) begin
      window_max_q  <= best;
      last_window_q <= end_of_sequence_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign window_max_o  = window_max_q;
  assign last_window_o = last_window_q;

endmodule : sliding_window_maximum

`default_nettype wire

>>> hdl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell: one candidate slot of the maximum chain
// Holds one candidate (value, age, valid). Per step it keeps its own
// content, pulls the right neighbor's, takes the new sample, or empties.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell #(
  parameter int unsigned SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned AGE_W        = 6
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire swm_pkg::cell_ctrl_t      ctrl_i,
  input  wire                           head_i,
  input  wire signed [SAMPLE_WIDTH-1:0] sample_i,
  input  wire                           lkeep_i,
  input  wire signed [SAMPLE_WIDTH-1:0] r_value_i,
  input  wire        [AGE_W-1:0]        r_age_i,
  input  wire                           r_valid_i,
  input  wire                           r_keep_i,
  output logic signed [SAMPLE_WIDTH-1:0] value_o,
  output logic       [AGE_W-1:0]        age_o,
  output logic                          valid_o,
  output logic                          keep_o
);

  logic signed [SAMPLE_WIDTH-1:0] value_q, value_d;
  logic [AGE_W-1:0]               age_q, age_d;
  logic                           valid_q, valid_d;

  logic                           keep_self;
  logic                           src_keep;
  logic                           prev_keep;
  logic signed [SAMPLE_WIDTH-1:0] src_value;
  logic [AGE_W-1:0]               src_age;

  // Survives the step on value alone (strictly greater than the new sample)
  assign keep_self = valid_q && (value_q > sample_i);

  always_comb begin
    src_value = ctrl_i.shift ? r_value_i : value_q;
    src_age   = ctrl_i.shift ? r_age_i   : age_q;
    src_keep  = ctrl_i.shift ? r_keep_i  : keep_self;
    // does the slot to our left end up holding a survivor?
    prev_keep = head_i ? 1'b1 : (ctrl_i.shift ? keep_self : lkeep_i);

    value_d = value_q;
    age_d   = age_q;
    valid_d = valid_q;
    if (ctrl_i.purge) begin
      value_d = r_value_i;
      age_d   = r_age_i;
      valid_d = r_valid_i;
    end else if (ctrl_i.step) begin
      if (src_keep) begin
        value_d = src_value;
        age_d   = src_age + AGE_W'(1);
        valid_d = 1'b1;
      end else if (prev_keep) begin
        // first free slot after the survivors takes the new sample
        value_d = sample_i;
        age_d   = '0;
        valid_d = 1'b1;
      end else begin
        valid_d = 1'b0;
      end
      if (ctrl_i.clear) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign age_o   = age_q;
  assign valid_o = valid_q;
  assign keep_o  = keep_self;

endmodule : swm_cell

`default_nettype wire

>>> hdl/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker: port-level checks for the sliding window maximum
// Watches the channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_checker #(
  parameter int unsigned SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           cfg_valid_i,
  input wire                           cfg_ready_o,
  input wire [swm_pkg::WS_W-1:0]       cfg_window_size_i,
  input wire                           in_valid_i,
  input wire                           in_stall_o,
  input wire signed [SAMPLE_WIDTH-1:0] sample_i,
  input wire                           end_of_sequence_i,
  input wire                           out_valid_o,
  input wire                           out_stall_i,
  input wire signed [SAMPLE_WIDTH-1:0] window_max_o,
  input wire                           last_window_o
);

  logic [swm_pkg::WS_W-1:0] ws_q;
  logic                     in_xact;

  assign in_xact = in_valid_i && !in_stall_o;

  // shadow of the window length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= swm_pkg::WS_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      ws_q <= cfg_window_size_i;
    end
  end

  // a held result is not overwritten while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(window_max_o)
      && $stable(last_window_o))
    else $error("result changed while stalled");

  // a new result only follows an input transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xact |=> !out_valid_o || $past(out_valid_o && out_stall_i))
    else $error("result without an input transaction");

  // a result right after an input transaction carries that sample's end flag
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xact |=> !out_valid_o || (last_window_o == $past(end_of_sequence_i)))
    else $error("last_window does not match end_of_sequence");

  // with a one-sample window every sample is its own maximum
  a_unit_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xact && (ws_q == swm_pkg::WS_W'(0) || ws_q == swm_pkg::WS_W'(1))
      |=> out_valid_o && (window_max_o == $past(sample_i)))
    else $error("unit window result mismatch");

endmodule : swm_checker

bind sliding_window_maximum swm_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .cfg_valid_i       (cfg_valid_i),
  .cfg_ready_o       (cfg_ready_o),
  .cfg_window_size_i (cfg_window_size_i),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .sample_i          (sample_i),
  .end_of_sequence_i (end_of_sequence_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .window_max_o      (window_max_o),
  .last_window_o     (last_window_o)
);

`default_nettype wire

>>> sim/sliding_window_maximum_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_maximum_tb: self-checking bench for the window maximum
// Walks a short directed table, then random sequences across many window
// settings; each result is checked against an in-bench model or a typed value.
// ----------------------------------------------------------------------------

module sliding_window_maximum_tb;

  localparam int CELLS       = swm_pkg::MAX_WINDOW_DEF;
  localparam int SW          = swm_pkg::SAMPLE_WIDTH_DEF;
  localparam int RAND_ITEMS  = 1900;
  localparam int CALM_ITEMS  = 200;      // tail of the run with no idling
  localparam int SETTLE      = 4;        // result lands in the cycle after accept
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PRINT_CAP   = 50;

  // Directed stimulus: a row either writes the window register or sends one
  // sample. Expected results are typed in only where they are obvious.
  typedef enum logic [0:0] {ROW_SAMPLE, ROW_WINDOW} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_VALUE} row_check_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [SW-1:0] value;     // sample, or window size for ROW_WINDOW
    logic       eos;
    row_check_e chk;
    logic [SW-1:0] exp_max;
    logic       exp_last;
  } stim_row_t;

  typedef struct packed {
    logic [SW-1:0] max_val;
    logic          last;
  } window_result_t;

  localparam int DIR_ROWS = 27;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // window 1 after reset: every sample is its own maximum
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, CHK_VALUE, 16'h7FFF, 1'b0},
    '{ROW_SAMPLE, 16'h8000, 1'b0, CHK_VALUE, 16'h8000, 1'b0},
    '{ROW_SAMPLE, 16'h0000, 1'b1, CHK_VALUE, 16'h0000, 1'b1},
    // window 4, equal values, then a full window
    '{ROW_WINDOW, 16'd4,    1'b0, CHK_NONE,  16'h0000, 1'b0},
    '{ROW_SAMPLE, 16'd5,    1'b0, CHK_NONE,  16'h0000, 1'b0},
    '{ROW_SAMPLE, 16'd5,    1'b0, CHK_NONE,  16'h0000, 1'b0},
    '{ROW_SAMPLE, 16'h8000, 1'b0, CHK_NONE,  16'h0000, 1'b0},
    '{ROW_SAMPLE, 16'd7,    1'b0, CHK_VALUE, 16'd7,    1'b0},
    '{ROW_SAMPLE, 16'hFFFF, 1'b0, CHK_MODEL, 16'h0000, 1'b0},
    '{ROW_SAMPLE, 16'hFFFE, 1'b0, CHK_MODEL, 16'h0000, 1'b0},
    '{ROW_SAMPLE, 16'hFFFD, 1'b0, CHK_MODEL, 16'h0000, 1'b0},
    '{ROW_SAMPLE, 16'hFFFC, 1'b1, CHK_MODEL, 16'h0000, 1'b0},
    // sequence shorter than the window: silent, but still clears
    '{ROW_SAMPLE, 16'd100,  1'b0, CHK_NONE,  16'h0000, 1'b0},
    '{ROW_SAMPLE, 16'd200,  1'b1, CHK_NONE,  16'h0000, 1'b0},
    // window zero behaves as one
    '{ROW_WINDOW, 16'd0,    1'b0, CHK_NONE,  16'h0000, 1'b0},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, CHK_VALUE, 16'h7FFF, 1'b0},
    '{ROW_SAMPLE, 16'hFFFB, 1'b1, CHK_VALUE, 16'hFFFB, 1'b1},
    // oversize window saturates; leave the sequence open
    '{ROW_WINDOW, 16'd127,  1'b0, CHK_NONE,  16'h0000, 1'b0},
    '{ROW_SAMPLE, 16'd9,    1'b0, CHK_NONE,  16'h0000, 1'b0},
    '{ROW_SAMPLE, 16'hFFF7, 1'b0, CHK_NONE,  16'h0000, 1'b0},
    '{ROW_SAMPLE, 16'd1,    1'b0, CHK_NONE,  16'h0000, 1'b0},
    // shrink mid-sequence: old candidates expire before the next sample
    '{ROW_WINDOW, 16'd2,    1'b0, CHK_NONE,  16'h0000, 1'b0},
    '{ROW_SAMPLE, 16'd4,    1'b0, CHK_MODEL, 16'h0000, 1'b0},
    '{ROW_SAMPLE, 16'hFFF9, 1'b0, CHK_MODEL, 16'h0000, 1'b0},
    // grow mid-sequence: dropped samples stay dropped
    '{ROW_WINDOW, 16'd5,    1'b0, CHK_NONE,  16'h0000, 1'b0},
    '{ROW_SAMPLE, 16'hFFF8, 1'b0, CHK_MODEL, 16'h0000, 1'b0},
    '{ROW_SAMPLE, 16'h7FFF, 1'b1, CHK_MODEL, 16'h0000, 1'b0}
  };

  // DUT connections; every input starts at a known value
  logic                     clk_i             = 1'b0;
  logic                     rst_ni            = 1'b0;
  logic                     cfg_valid_i       = 1'b0;
  logic                     cfg_ready_o;
  logic [swm_pkg::WS_W-1:0] cfg_window_size_i = '0;
  logic                     in_valid_i        = 1'b0;
  logic                     in_stall_o;
  logic [SW-1:0]            sample_i          = '0;
  logic                     end_of_sequence_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i       = 1'b0;
  logic [SW-1:0]            window_max_o;
  logic                     last_window_o;

  // Window model: candidate cells, their ages, and the sequence count
  logic signed [SW-1:0]     cand_val  [CELLS];
  bit [5:0]                 cand_age  [CELLS];
  bit                       cand_live [CELLS];
  int                       seq_count = 0;
  logic [swm_pkg::WS_W-1:0] win_reg   = 7'd1;

  window_result_t pending_maxima[$];
  logic [SW-1:0]  prev_sample  = '0;
  int             mismatches   = 0;
  int             samples_sent = 0;
  int             stall_left   = 0;
  int             cycle_count  = 0;
  bit             calm         = 1'b0;   // set for the final stretch

  sliding_window_maximum u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_window_size_i(cfg_window_size_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .end_of_sequence_i(end_of_sequence_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .window_max_o     (window_max_o),
    .last_window_o    (last_window_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop in case a handshake never completes
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Register value as the block uses it: 0 acts as 1, oversize saturates
  function automatic int clamp_window(input logic [swm_pkg::WS_W-1:0] ws);
    if (ws == 0) return 1;
    if (ws > CELLS) return CELLS;
    return int'(ws);
  endfunction

  // One sample step of the window model. Returns 1 when a window maximum
  // comes out of this sample; the maximum goes to max_out.
  function automatic bit slide_window(input logic [SW-1:0] raw, input logic eos,
                                      output logic [SW-1:0] max_out);
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] best;
    int                   k;
    int                   free_idx;
    bit                   produced;
    x        = $signed(raw);
    k        = clamp_window(win_reg);
    best     = x;
    free_idx = -1;
    // expire old candidates and those the new sample dominates (ties too)
    for (int i = 0; i < CELLS; i++) begin
      if (cand_live[i]) begin
        if (int'(cand_age[i]) + 1 >= k || cand_val[i] <= x) begin
          cand_live[i] = 1'b0;
          cand_age[i]  = '0;
        end else begin
          cand_age[i] = cand_age[i] + 6'd1;
        end
      end
    end
    for (int i = 0; i < CELLS; i++) begin
      if (cand_live[i]) begin
        if (cand_val[i] > best) best = cand_val[i];
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (free_idx >= 0) begin
      cand_val[free_idx]  = x;
      cand_age[free_idx]  = '0;
      cand_live[free_idx] = 1'b1;
    end
    if (seq_count < CELLS) seq_count++;
    produced = (seq_count >= k);
    max_out  = best;
    if (eos) begin
      for (int i = 0; i < CELLS; i++) begin
        cand_live[i] = 1'b0;
        cand_age[i]  = '0;
      end
      seq_count = 0;
    end
    return produced;
  endfunction

  // Random sample with a bias toward ties, ramps and the two extremes
  function automatic logic [SW-1:0] next_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: prev_sample = SW'($urandom);
      4, 5, 6:    prev_sample = SW'($urandom_range(0, 8) - 4);
      7:          prev_sample = prev_sample + 1'b1;
      8:          prev_sample = prev_sample - 1'b1;
      default:    prev_sample = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    endcase
    return prev_sample;
  endfunction

  // Write window_size with the block idle: drain results, let it settle,
  // then run the config transaction. Called at a rising edge.
  task automatic write_window(input logic [swm_pkg::WS_W-1:0] ws);
    in_valid_i <= 1'b0;
    while (pending_maxima.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_window_size_i <= ws;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    win_reg = ws;
  endtask

  // Send one sample transaction, maybe after an idle burst, and record what
  // should come out of it. Called at a rising edge, returns at the accept edge.
  task automatic feed_sample(input logic [SW-1:0] s, input logic eos,
                             input row_check_e chk, input logic [SW-1:0] exp_max,
                             input logic exp_last);
    logic [SW-1:0] model_max;
    bit            produced;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    sample_i          <= s;
    end_of_sequence_i <= eos;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    // accepted at this edge; the model always advances
    produced = slide_window(s, eos, model_max);
    case (chk)
      CHK_MODEL: if (produced) pending_maxima.push_back('{model_max, eos});
      CHK_VALUE: pending_maxima.push_back('{exp_max, exp_last});
      default:   ;
    endcase
    samples_sent++;
  endtask

  // Output side: random stall bursts and the result checker. Both read
  // pre-edge values, same as the DUT sees them.
  always @(posedge clk_i) begin
    window_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_maxima.size() == 0) begin
        report_mismatch($sformatf("unexpected result max=%0d last=%0b",
                                  $signed(window_max_o), last_window_o));
      end else begin
        want = pending_maxima.pop_front();
        if (window_max_o !== want.max_val)
          report_mismatch($sformatf("window_max got %0d want %0d",
                                    $signed(window_max_o), $signed(want.max_val)));
        if (last_window_o !== want.last)
          report_mismatch($sformatf("last_window got %0b want %0b",
                                    last_window_o, want.last));
      end
    end
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 13);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Main sequence: reset, directed table, random phases, drain, verdict
  initial begin
    logic [swm_pkg::WS_W-1:0] ws;
    int                       keff;
    int                       nseq;
    int                       len;
    bit                       open_end;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_WINDOW)
        write_window(DIRECTED[r].value[swm_pkg::WS_W-1:0]);
      else
        feed_sample(DIRECTED[r].value, DIRECTED[r].eos, DIRECTED[r].chk,
                    DIRECTED[r].exp_max, DIRECTED[r].exp_last);
    end

    // Random phases: pick a window, then a few sequences under it. Most are
    // long enough to produce results; some are short, and the last one may
    // stay open so the next write lands mid-sequence.
    samples_sent = 0;
    while (samples_sent < RAND_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       ws = 7'd0;
        1:       ws = 7'd1;
        2:       ws = 7'd64;
        3:       ws = 7'($urandom_range(65, 127));
        4, 5:    ws = 7'($urandom_range(9, 63));
        default: ws = 7'($urandom_range(2, 8));
      endcase
      write_window(ws);
      keff = clamp_window(ws);
      nseq = $urandom_range(1, 4);
      for (int q = 0; q < nseq; q++) begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, keff);
        else                            len = keff + $urandom_range(0, 20);
        open_end = (q == nseq - 1) && ($urandom_range(0, 3) == 0);
        for (int j = 0; j < len; j++) begin
          calm = (samples_sent >= RAND_ITEMS - CALM_ITEMS);
          feed_sample(next_sample(), (j == len - 1) && !open_end, CHK_MODEL,
                      '0, 1'b0);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_maxima.size() != 0) @(posedge clk_i);
    repeat (2 * SETTLE) @(posedge clk_i);
    if (mismatches == 0) $display("Regression PASS");
    else                 $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
hdl/swm_pkg.sv
hdl/swm_cell.sv
hdl/sliding_window_maximum.sv
hdl/swm_checker.sv
sim/sliding_window_maximum_tb.sv
